// File: src/spq_pkg.sv
package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int TIME_W = 16;

   localparam logic [1:0] ST_ENQ = 2'd0;
   localparam logic [1:0] ST_DEQ = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   localparam logic CMD_ENQ = 1'b0;
   localparam logic CMD_DEQ = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  entry_tag;
      logic [3:0]  priority_req;
      logic [15:0] arrival_time;
      logic [9:0]  service_time;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  out_tag;
      logic [3:0]  out_priority;
      logic [15:0] out_arrival;
      logic [15:0] start_time;
      logic [15:0] wait_time;
      logic [15:0] finish_time;
      logic [4:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  tag;
      logic [3:0]  prio;
      logic [15:0] arrival;
      logic [9:0]  duration;
   } entry_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ENQ_CMP,
      S_ENQ_WR,
      S_DEQ_MAX,
      S_DEQ_WAIT,
      S_DEQ_FIN,
      S_DONE
   } state_type;

   function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] hd,
                                                   input logic [CNT_W-1:0] idx);
      logic [SUM_W-1:0] s;
      s = SUM_W'(hd) + SUM_W'(idx);
      if (s >= SUM_W'(QUEUE_DEPTH)) begin
         s = s - SUM_W'(QUEUE_DEPTH);
      end
      return s[ADDR_W-1:0];
   endfunction

endpackage

// File: src/stable_priority_queue_with_service_times_unit.sv
// Stable priority queue with single-server scheduling.
// req channel (req_valid/req_ready/req_data): one transaction per command,
// enqueue (cmd 0) or dequeue (cmd 1). rsp channel (rsp_valid/rsp_ready/
// rsp_data): exactly one result transaction per command, in command order.
// Entries live in a circular buffer in a RAM with one write and one read
// port. An enqueue walks back from the tail, moving each lower-priority
// entry one place down, one entry per cycle through the single write port;
// the new entry is written in a separate step when it lands at the head.
// A dequeue reads the head and runs start, wait and finish through one
// shared adder/subtractor in three steps. Full and empty cases go straight
// to the result.
// req_ready is high only while the sequencer is idle, so no command is taken
// until the previous one is done; a new command may be taken while the previous
// result still sits in the output register. When the receiver stalls, the
// finished result waits in a holding register and the sequencer stops until
// the output register frees.
// Reset (synchronous, active high) empties the queue, clears the last
// finish time and drops any pending result; no memory clearing is needed.
module stable_priority_queue_with_service_times_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] hd_ff, hd_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   entry_type         new_ff, new_in;
   entry_type         head_ff, head_in;
   logic [TIME_W-1:0] start_ff, start_in;
   logic [TIME_W-1:0] wait_ff, wait_in;
   logic [TIME_W-1:0] lf_ff, lf_in;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   entry_type         wr_data, rd_data;
   alu_op_type        alu_op;
   logic [TIME_W-1:0] alu_a, alu_b;
   logic [TIME_W:0]   alu_y;
   logic [CNT_W-1:0]  km1;
   logic              req_fire;

   spq_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   spq_alu u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire = req_valid && req_ready;
   assign km1 = k_ff - CNT_W'(1);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         hd_ff <= '0;
         lf_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         hd_ff <= hd_in;
         lf_ff <= lf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff <= k_in;
      new_ff <= new_in;
      head_ff <= head_in;
      start_ff <= start_in;
      wait_ff <= wait_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      hd_in = hd_ff;
      k_in = k_ff;
      new_in = new_ff;
      head_in = head_ff;
      start_in = start_ff;
      wait_in = wait_ff;
      lf_in = lf_ff;
      res_in = res_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en = 1'b0;
      wr_addr = phys_addr(hd_ff, k_ff);
      wr_data = new_ff;
      rd_en = 1'b0;
      rd_addr = phys_addr(hd_ff, km1);
      alu_op = ALU_SUB;
      alu_a = TIME_W'(rd_data.prio);
      alu_b = TIME_W'(new_ff.prio);

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_in = '0;
               new_in.tag = req_data.entry_tag;
               new_in.prio = req_data.priority_req;
               new_in.arrival = req_data.arrival_time;
               new_in.duration = req_data.service_time;
               if (req_data.cmd == CMD_ENQ) begin
                  if (cnt_ff == CNT_W'(QUEUE_DEPTH)) begin
                     res_in.status = ST_FULL;
                     res_in.occupancy = 5'(cnt_ff);
                     state_in = S_DONE;
                  end else if (cnt_ff == '0) begin
                     k_in = '0;
                     state_in = S_ENQ_WR;
                  end else begin
                     k_in = cnt_ff;
                     rd_en = 1'b1;
                     rd_addr = phys_addr(hd_ff, cnt_ff - CNT_W'(1));
                     state_in = S_ENQ_CMP;
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     res_in.status = ST_EMPTY;
                     res_in.occupancy = 5'(cnt_ff);
                     state_in = S_DONE;
                  end else begin
                     rd_en = 1'b1;
                     rd_addr = hd_ff;
                     state_in = S_DEQ_MAX;
                  end
               end
            end
         end
         S_ENQ_CMP: begin
            if (alu_y[TIME_W]) begin
               wr_en = 1'b1;
               wr_data = rd_data;
               k_in = km1;
               if (km1 == '0) begin
                  state_in = S_ENQ_WR;
               end else begin
                  rd_en = 1'b1;
                  rd_addr = phys_addr(hd_ff, km1 - CNT_W'(1));
               end
            end else begin
               wr_en = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
               res_in.status = ST_ENQ;
               res_in.occupancy = 5'(cnt_ff + CNT_W'(1));
               state_in = S_DONE;
            end
         end
         S_ENQ_WR: begin
            wr_en = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            res_in.status = ST_ENQ;
            res_in.occupancy = 5'(cnt_ff + CNT_W'(1));
            state_in = S_DONE;
         end
         S_DEQ_MAX: begin
            head_in = rd_data;
            alu_a = lf_ff;
            alu_b = rd_data.arrival;
            start_in = alu_y[TIME_W] ? rd_data.arrival : lf_ff;
            state_in = S_DEQ_WAIT;
         end
         S_DEQ_WAIT: begin
            alu_a = start_ff;
            alu_b = head_ff.arrival;
            wait_in = alu_y[TIME_W-1:0];
            state_in = S_DEQ_FIN;
         end
         S_DEQ_FIN: begin
            alu_op = ALU_ADD;
            alu_a = start_ff;
            alu_b = TIME_W'(head_ff.duration);
            lf_in = alu_y[TIME_W] ? {TIME_W{1'b1}} : alu_y[TIME_W-1:0];
            hd_in = phys_addr(hd_ff, CNT_W'(1));
            cnt_in = cnt_ff - CNT_W'(1);
            res_in.status = ST_DEQ;
            res_in.out_tag = head_ff.tag;
            res_in.out_priority = head_ff.prio;
            res_in.out_arrival = head_ff.arrival;
            res_in.start_time = start_ff;
            res_in.wait_time = wait_ff;
            res_in.finish_time = alu_y[TIME_W] ? {TIME_W{1'b1}} : alu_y[TIME_W-1:0];
            res_in.occupancy = 5'(cnt_ff - CNT_W'(1));
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: src/spq_ram.sv
module spq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/spq_alu.sv
module spq_alu (
   input  spq_pkg::alu_op_type          op,
   input  logic [spq_pkg::TIME_W-1:0]   a,
   input  logic [spq_pkg::TIME_W-1:0]   b,
   output logic [spq_pkg::TIME_W:0]     y
);
   import spq_pkg::*;

   always_comb begin
      case (op)
         ALU_ADD: y = {1'b0, a} + {1'b0, b};
         ALU_SUB: y = {1'b0, a} - {1'b0, b};
         default: y = '0;
      endcase
   end

endmodule
